FILE: rtl/anpr_pkg.sv
// Package for the AArch64 next-PC resolver: branch kinds, opcode match values,
// condition code groups and the decode result struct.
// No dependencies.
`timescale 1ns / 1ps

package anpr_pkg;

    typedef enum logic [3:0] {
        KIND_NONE  = 4'd0,
        KIND_BCOND = 4'd1,
        KIND_CBZ   = 4'd2,
        KIND_CBNZ  = 4'd3,
        KIND_TBZ   = 4'd4,
        KIND_TBNZ  = 4'd5,
        KIND_B     = 4'd6,
        KIND_BL    = 4'd7,
        KIND_BR    = 4'd8,
        KIND_BLR   = 4'd9,
        KIND_RET   = 4'd10,
        KIND_ERET  = 4'd11
    } kind_t;

    // Top byte / masked top byte match values
    localparam logic [7:0]  OP_BCOND = 8'h54;
    localparam logic [6:0]  OP_CBZ   = 7'h34;
    localparam logic [6:0]  OP_CBNZ  = 7'h35;
    localparam logic [6:0]  OP_TBZ   = 7'h36;
    localparam logic [6:0]  OP_TBNZ  = 7'h37;
    localparam logic [5:0]  OP_B     = 6'b000101;
    localparam logic [5:0]  OP_BL    = 6'b100101;
    // Bits 31..10 of the register branches
    localparam logic [21:0] MID_BR   = 22'h3587C0;
    localparam logic [21:0] MID_BLR  = 22'h358FC0;
    localparam logic [21:0] MID_RET  = 22'h3597C0;
    localparam logic [31:0] WORD_ERET = 32'hD69F03E0;

    // Condition code groups (cond[3:1])
    localparam logic [2:0] CG_EQ = 3'd0;
    localparam logic [2:0] CG_CS = 3'd1;
    localparam logic [2:0] CG_MI = 3'd2;
    localparam logic [2:0] CG_VS = 3'd3;
    localparam logic [2:0] CG_HI = 3'd4;
    localparam logic [2:0] CG_GE = 3'd5;
    localparam logic [2:0] CG_GT = 3'd6;
    localparam logic [2:0] CG_AL = 3'd7;

    localparam int unsigned PC_W = 64;

    typedef struct packed {
        kind_t kind;
        logic  taken;
        logic  sel_reg;   // next PC comes from the register value
    } decode_t;

endpackage

FILE: rtl/anpr_decode.sv
// Instruction classification, condition evaluation and branch offset selection.
// Depends on anpr_pkg.
`timescale 1ns / 1ps

module anpr_decode (
    input  logic [31:0]             instr_word,
    input  logic [3:0]              flags_nzcv,
    input  logic [63:0]             reg_value,
    output anpr_pkg::decode_t       dec,
    output logic [anpr_pkg::PC_W-1:0] offset
);

    logic [7:0]  top;
    logic [21:0] mid;
    logic        n_f, z_f, c_f, v_f;
    logic        cond_base;
    logic        cond_ok;
    logic        is_zero;
    logic        bit_clr;
    logic [5:0]  bit_pos;
    logic [63:0] off_19;
    logic [63:0] off_14;
    logic [63:0] off_26;

    assign top = instr_word[31:24];
    assign mid = instr_word[31:10];
    assign {n_f, z_f, c_f, v_f} = flags_nzcv;

    assign off_19 = {{43{instr_word[23]}}, instr_word[23:5], 2'b00};
    assign off_14 = {{48{instr_word[18]}}, instr_word[18:5], 2'b00};
    assign off_26 = {{36{instr_word[25]}}, instr_word[25:0], 2'b00};

    always_comb
    begin
        case (instr_word[3:1])
            anpr_pkg::CG_EQ: cond_base = z_f;
            anpr_pkg::CG_CS: cond_base = c_f;
            anpr_pkg::CG_MI: cond_base = n_f;
            anpr_pkg::CG_VS: cond_base = v_f;
            anpr_pkg::CG_HI: cond_base = c_f & ~z_f;
            anpr_pkg::CG_GE: cond_base = (n_f == v_f);
            anpr_pkg::CG_GT: cond_base = ~z_f & (n_f == v_f);
            default:         cond_base = 1'b1;
        endcase
        // AL and NV both hold
        if (instr_word[3:1] == anpr_pkg::CG_AL)
            cond_ok = 1'b1;
        else
            cond_ok = cond_base ^ instr_word[0];
    end

    assign is_zero = instr_word[31] ? (reg_value == 64'd0) : (reg_value[31:0] == 32'd0);
    assign bit_pos = {instr_word[31], instr_word[23:19]};
    assign bit_clr = ~reg_value[bit_pos];

    always_comb
    begin
        dec.kind    = anpr_pkg::KIND_NONE;
        dec.taken   = 1'b0;
        dec.sel_reg = 1'b0;
        offset      = 64'd4;
        if (top == anpr_pkg::OP_BCOND)
        begin
            dec.kind  = anpr_pkg::KIND_BCOND;
            dec.taken = cond_ok;
        end
        else if (top[6:0] == anpr_pkg::OP_CBNZ)
        begin
            dec.kind  = anpr_pkg::KIND_CBNZ;
            dec.taken = ~is_zero;
        end
        else if (top[6:0] == anpr_pkg::OP_CBZ)
        begin
            dec.kind  = anpr_pkg::KIND_CBZ;
            dec.taken = is_zero;
        end
        else if (top[6:0] == anpr_pkg::OP_TBNZ)
        begin
            dec.kind  = anpr_pkg::KIND_TBNZ;
            dec.taken = ~bit_clr;
        end
        else if (top[6:0] == anpr_pkg::OP_TBZ)
        begin
            dec.kind  = anpr_pkg::KIND_TBZ;
            dec.taken = bit_clr;
        end
        else if (top[7:2] == anpr_pkg::OP_B)
        begin
            dec.kind  = anpr_pkg::KIND_B;
            dec.taken = 1'b1;
        end
        else if (top[7:2] == anpr_pkg::OP_BL)
        begin
            dec.kind  = anpr_pkg::KIND_BL;
            dec.taken = 1'b1;
        end
        else if (mid == anpr_pkg::MID_BLR && instr_word[4:0] == 5'd0)
        begin
            dec.kind    = anpr_pkg::KIND_BLR;
            dec.taken   = 1'b1;
            dec.sel_reg = 1'b1;
        end
        else if (mid == anpr_pkg::MID_BR && instr_word[4:0] == 5'd0)
        begin
            dec.kind    = anpr_pkg::KIND_BR;
            dec.taken   = 1'b1;
            dec.sel_reg = 1'b1;
        end
        else if (mid == anpr_pkg::MID_RET && instr_word[4:0] == 5'd0)
        begin
            dec.kind    = anpr_pkg::KIND_RET;
            dec.taken   = 1'b1;
            dec.sel_reg = 1'b1;
        end
        else if (instr_word == anpr_pkg::WORD_ERET)
        begin
            dec.kind = anpr_pkg::KIND_ERET;
        end

        // PC-relative offset only when the branch is taken
        if (dec.taken && !dec.sel_reg)
        begin
            unique case (dec.kind)
                anpr_pkg::KIND_TBZ, anpr_pkg::KIND_TBNZ: offset = off_14;
                anpr_pkg::KIND_B, anpr_pkg::KIND_BL:     offset = off_26;
                default:                                 offset = off_19;
            endcase
        end
    end

endmodule

FILE: rtl/anpr_target.sv
// Next-PC formation: one 64-bit add of PC and offset, or the register value.
// Depends on anpr_pkg.
`timescale 1ns / 1ps

module anpr_target (
    input  logic [anpr_pkg::PC_W-1:0] instr_addr,
    input  logic [anpr_pkg::PC_W-1:0] reg_value,
    input  logic [anpr_pkg::PC_W-1:0] offset,
    input  anpr_pkg::decode_t         dec,
    output logic [anpr_pkg::PC_W-1:0] next_pc
);

    logic [anpr_pkg::PC_W-1:0] sum;

    // wraps modulo 2^64
    assign sum     = instr_addr + offset;
    assign next_pc = dec.sel_reg ? reg_value : sum;

endmodule

FILE: rtl/aarch64_next_pc_resolver_top.sv
// Top level of the AArch64 next-PC resolver: input register, decode, target add
// and result register. Depends on anpr_pkg, anpr_decode and anpr_target.
`timescale 1ns / 1ps

// Usage
//   Slave channel s_*: one request per instruction, carrying the word, its address,
//   the NZCV flags and the value of the register the instruction names (Rt for
//   CBZ/CBNZ/TBZ/TBNZ, Rn for BR/BLR/RET, don't care otherwise).
//   Master channel m_*: one result per request, in order: next PC in m_tdata, the
//   branch kind and the taken flag in m_tuser.
//   Path: a request accepted on s_* is captured in the input register, then goes
//   through decode and one 64-bit add into the result register, which drives m_*.
//   Throughput: one request per cycle, sustained, while m_tready stays high; the
//   single 64-bit PC adder and the decode sit combinationally between the registers.
//   Stall: each stage holds its contents while the next is full and not drained;
//   s_tready drops only once both stages hold requests and m_tready is low, so a
//   finished result waiting on the master side does not block a new request.
//   Reset: rst_n low clears both stage valid flags at once; no result is pending
//   afterwards. The block keeps no state between requests.

module aarch64_next_pc_resolver_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] instr_word, [95:32] instr_addr, [99:96] flags_nzcv,
    // [163:100] reg_value, [167:164] zero
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] next_pc
    output logic [63:0]  m_tdata,
    // [3:0] branch_kind, [4] taken
    output logic [4:0]   m_tuser
);

    // stage 1: captured request
    logic        v1_reg;
    logic [31:0] word_reg;
    logic [63:0] addr_reg;
    logic [3:0]  nzcv_reg;
    logic [63:0] rval_reg;

    // stage 2: result register
    logic        v2_reg;
    logic [63:0] pc_out_reg;
    logic [3:0]  kind_out_reg;
    logic        taken_out_reg;

    logic              adv1;    // stage 1 moves into stage 2
    logic              ready2;
    anpr_pkg::decode_t dec;
    logic [63:0]       offset;
    logic [63:0]       next_pc;

    assign ready2   = !v2_reg || m_tready;
    assign adv1     = v1_reg && ready2;
    assign s_tready = !v1_reg || ready2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                v1_reg <= s_tvalid;
            if (ready2)
                v2_reg <= v1_reg;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg <= s_tdata[31:0];
            addr_reg <= s_tdata[95:32];
            nzcv_reg <= s_tdata[99:96];
            rval_reg <= s_tdata[163:100];
        end
        if (adv1)
        begin
            pc_out_reg    <= next_pc;
            kind_out_reg  <= dec.kind;
            taken_out_reg <= dec.taken;
        end
    end

    anpr_decode u_decode (
        .instr_word (word_reg),
        .flags_nzcv (nzcv_reg),
        .reg_value  (rval_reg),
        .dec        (dec),
        .offset     (offset)
    );

    anpr_target u_target (
        .instr_addr (addr_reg),
        .reg_value  (rval_reg),
        .offset     (offset),
        .dec        (dec),
        .next_pc    (next_pc)
    );

    assign m_tvalid = v2_reg;
    assign m_tdata  = pc_out_reg;
    assign m_tuser  = {taken_out_reg, kind_out_reg};

endmodule

FILE: rtl/anpr_checker.sv
// Port-level checker for the next-PC resolver, with its bind to the top level.
// Depends on anpr_pkg and aarch64_next_pc_resolver_top.
`timescale 1ns / 1ps

module anpr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [4:0]   m_tuser
);

    // held result stays put while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // non-branches and ERET never report taken
    a_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[3:0] == anpr_pkg::KIND_NONE
                     || m_tuser[3:0] == anpr_pkg::KIND_ERET) |-> !m_tuser[4])
        else $error("taken set on a sequential kind");

    // register and unconditional branches are always taken
    a_always_taken: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[3:0] == anpr_pkg::KIND_BR
                     || m_tuser[3:0] == anpr_pkg::KIND_BLR
                     || m_tuser[3:0] == anpr_pkg::KIND_RET
                     || m_tuser[3:0] == anpr_pkg::KIND_B
                     || m_tuser[3:0] == anpr_pkg::KIND_BL) |-> m_tuser[4])
        else $error("unconditional branch not taken");

    // a request accepted while the result register is empty leads to m_tvalid once it has passed both registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> ##0 1'b1 ##1 m_tvalid)
        else $error("result missing after request");

endmodule

bind aarch64_next_pc_resolver_top anpr_checker u_anpr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
